[hdl/ustv_pkg.sv]
// ============================================================================
// ustv_pkg
// Shared types, codes and tables of the UTF-8 stream validator.
// ============================================================================
package ustv_pkg;

    localparam int CFG_W     = 17;
    localparam int SAFE_W    = 16;
    localparam int CLASS_W   = 4;
    localparam int STATE_W   = 4;
    localparam int NUM_STATE = 9;
    localparam int NUM_CLASS = 12;

    localparam logic [CFG_W-1:0] CAPACITY_RESET = 17'd65536;

    localparam logic [STATE_W-1:0] ST_ACCEPT = 4'd0;
    localparam logic [STATE_W-1:0] ST_REJECT = 4'd1;
    localparam logic [STATE_W-1:0] ST_LAST   = 4'd8;

    localparam logic [1:0] STATUS_VALID      = 2'd0;
    localparam logic [1:0] STATUS_INVALID    = 2'd1;
    localparam logic [1:0] STATUS_INCOMPLETE = 2'd2;

    localparam logic ACTION_FEED    = 1'b0;
    localparam logic ACTION_RESTART = 1'b1;

    typedef enum logic [1:0] {
        CMD_FEED,
        CMD_ZERO,
        CMD_RESTART
    } t_cmd_kind;

    typedef struct packed {
        logic       action;
        logic [7:0] data_byte;
    } t_in_item;

    typedef struct packed {
        logic [1:0]        status;
        logic [SAFE_W-1:0] safe_length;
        logic              copy_stopped;
    } t_out_item;

    typedef struct packed {
        t_cmd_kind          kind;
        logic [CLASS_W-1:0] byte_class;
    } t_cmd;

    localparam logic [STATE_W-1:0] NEXT_STATE [0:NUM_STATE-1][0:NUM_CLASS-1] = '{
        '{4'd0, 4'd1, 4'd2, 4'd3, 4'd5, 4'd8, 4'd7, 4'd1, 4'd1, 4'd1, 4'd4, 4'd6},
        '{4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1},
        '{4'd1, 4'd0, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd0, 4'd1, 4'd0, 4'd1, 4'd1},
        '{4'd1, 4'd2, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd2, 4'd1, 4'd2, 4'd1, 4'd1},
        '{4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd2, 4'd1, 4'd1, 4'd1, 4'd1},
        '{4'd1, 4'd2, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd2, 4'd1, 4'd1},
        '{4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd3, 4'd1, 4'd3, 4'd1, 4'd1},
        '{4'd1, 4'd3, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd3, 4'd1, 4'd3, 4'd1, 4'd1},
        '{4'd1, 4'd3, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1}
    };

    function automatic logic [CLASS_W-1:0] byte_class(input logic [7:0] b);
        logic [CLASS_W-1:0] c;
        case (b) inside
            [8'h00:8'h7F]: c = 4'd0;
            [8'h80:8'h8F]: c = 4'd1;
            [8'h90:8'h9F]: c = 4'd9;
            [8'hA0:8'hBF]: c = 4'd7;
            [8'hC0:8'hC1]: c = 4'd8;
            [8'hC2:8'hDF]: c = 4'd2;
            8'hE0:         c = 4'd10;
            8'hED:         c = 4'd4;
            [8'hE1:8'hEF]: c = 4'd3;
            8'hF0:         c = 4'd11;
            [8'hF1:8'hF3]: c = 4'd6;
            8'hF4:         c = 4'd5;
            default:       c = 4'd8;
        endcase
        return c;
    endfunction

endpackage

[hdl/ustv_queue.sv]
// ============================================================================
// ustv_queue
// Small register FIFO that decouples two pipeline sections.
// ============================================================================
module ustv_queue #(
    parameter type T     = logic,
    parameter int  DEPTH = 2
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  T     i_data,
    output logic o_full,
    input  logic i_pop,
    output T     o_data,
    output logic o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    T                r_mem [0:DEPTH-1];
    logic [AW-1:0]   r_wr_ptr;
    logic [AW-1:0]   r_rd_ptr;
    logic [CW-1:0]   r_count;
    logic            w_do_push;
    logic            w_do_pop;

    assign o_full    = (r_count == CW'(DEPTH));
    assign o_empty   = (r_count == '0);
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && !o_empty;
    assign o_data    = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_do_push) begin
                r_wr_ptr <= (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_do_pop) begin
                r_rd_ptr <= (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_do_push && !w_do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_do_pop && !w_do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

[hdl/ustv_front.sv]
// ============================================================================
// ustv_front
// Accepts input requests and classifies them into commands for the back end.
// ============================================================================
module ustv_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  ustv_pkg::t_in_item i_item,
    output logic              o_full,
    output logic              o_cmd_valid,
    output ustv_pkg::t_cmd    o_cmd,
    input  logic              i_cmd_full
);

    logic            r_valid;
    ustv_pkg::t_cmd  r_cmd;
    ustv_pkg::t_cmd  n_cmd;
    logic            w_ready;
    logic            w_accept;

    assign w_ready     = !r_valid || !i_cmd_full;
    assign o_full      = !w_ready;
    assign w_accept    = i_push && w_ready;
    assign o_cmd_valid = r_valid;
    assign o_cmd       = r_cmd;

    always_comb begin
        n_cmd.byte_class = ustv_pkg::byte_class(i_item.data_byte);
        if (i_item.action == ustv_pkg::ACTION_RESTART) begin
            n_cmd.kind = ustv_pkg::CMD_RESTART;
        end else if (i_item.data_byte == 8'h00) begin
            n_cmd.kind = ustv_pkg::CMD_ZERO;
        end else begin
            n_cmd.kind = ustv_pkg::CMD_FEED;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd <= n_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_ready) begin
            r_valid <= i_push;
        end
    end

endmodule

[hdl/ustv_back.sv]
// ============================================================================
// ustv_back
// Steps the UTF-8 automaton and the safe-truncation tracker, one command
// per cycle unless i_res_full, and emits one result request per command.
// ============================================================================
module ustv_back #(
    parameter int LENGTH_BITS = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_wr_en,
    input  logic [ustv_pkg::CFG_W-1:0]         i_cfg_wr_data,
    input  logic                               i_cmd_valid,
    input  ustv_pkg::t_cmd                     i_cmd,
    output logic                               o_cmd_take,
    output logic                               o_res_valid,
    output ustv_pkg::t_out_item                o_res,
    input  logic                               i_res_full
);

    localparam int TW = LENGTH_BITS + 1;
    localparam int CW = (TW > ustv_pkg::CFG_W) ? TW : ustv_pkg::CFG_W;

    logic [ustv_pkg::STATE_W-1:0] r_dfa;
    logic [ustv_pkg::STATE_W-1:0] n_dfa;
    logic [TW-1:0]                r_taken;
    logic [TW-1:0]                n_taken;
    logic [LENGTH_BITS-1:0]       r_bound;
    logic [LENGTH_BITS-1:0]       n_bound;
    logic                         r_halt;
    logic                         n_halt;
    logic [ustv_pkg::CFG_W-1:0]   r_cap;

    logic [ustv_pkg::STATE_W-1:0] w_cur;
    logic [ustv_pkg::STATE_W-1:0] w_step;
    logic [CW-1:0]                w_cap_ext;
    logic [CW-1:0]                w_lim;
    logic [CW-1:0]                w_eff_cap;
    logic [TW-1:0]                w_taken_inc;
    logic [LENGTH_BITS+ustv_pkg::SAFE_W-1:0] w_bound_ext;
    logic                         w_go;

    assign w_go        = i_cmd_valid && !i_res_full;
    assign o_cmd_take  = w_go;
    assign o_res_valid = w_go;

    assign w_cur       = (r_dfa > ustv_pkg::ST_LAST) ? ustv_pkg::ST_REJECT : r_dfa;
    assign w_step      = ustv_pkg::NEXT_STATE[w_cur][i_cmd.byte_class];
    assign w_cap_ext   = CW'(r_cap);
    assign w_lim       = CW'(1) << LENGTH_BITS;
    assign w_eff_cap   = (w_cap_ext > w_lim) ? w_lim : w_cap_ext;
    assign w_taken_inc = r_taken + 1'b1;

    always_comb begin
        n_dfa   = r_dfa;
        n_taken = r_taken;
        n_bound = r_bound;
        n_halt  = r_halt;
        case (i_cmd.kind)
            ustv_pkg::CMD_RESTART: begin
                n_dfa   = ustv_pkg::ST_ACCEPT;
                n_taken = '0;
                n_bound = '0;
                n_halt  = 1'b0;
            end
            ustv_pkg::CMD_ZERO: begin
                n_halt = 1'b1;
            end
            ustv_pkg::CMD_FEED: begin
                n_dfa = w_step;
                if (!r_halt) begin
                    if (CW'(r_taken) >= w_eff_cap || w_step == ustv_pkg::ST_REJECT) begin
                        n_halt = 1'b1;
                    end else begin
                        n_taken = w_taken_inc;
                        if (CW'(w_taken_inc) >= w_eff_cap) begin
                            n_halt = 1'b1;
                        end else if (w_step == ustv_pkg::ST_ACCEPT) begin
                            n_bound = w_taken_inc[LENGTH_BITS-1:0];
                        end
                    end
                end
            end
            default: begin
                n_dfa = r_dfa;
            end
        endcase
    end

    assign w_bound_ext = {{ustv_pkg::SAFE_W{1'b0}}, n_bound};

    always_comb begin
        if (n_dfa == ustv_pkg::ST_ACCEPT) begin
            o_res.status = ustv_pkg::STATUS_VALID;
        end else if (n_dfa == ustv_pkg::ST_REJECT || n_dfa > ustv_pkg::ST_LAST) begin
            o_res.status = ustv_pkg::STATUS_INVALID;
        end else begin
            o_res.status = ustv_pkg::STATUS_INCOMPLETE;
        end
        o_res.safe_length  = w_bound_ext[ustv_pkg::SAFE_W-1:0];
        o_res.copy_stopped = n_halt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dfa   <= ustv_pkg::ST_ACCEPT;
            r_taken <= '0;
            r_bound <= '0;
            r_halt  <= 1'b0;
            r_cap   <= ustv_pkg::CAPACITY_RESET;
        end else begin
            if (i_cfg_wr_en) begin
                r_cap <= i_cfg_wr_data;
            end
            if (w_go) begin
                r_dfa   <= n_dfa;
                r_taken <= n_taken;
                r_bound <= n_bound;
                r_halt  <= n_halt;
            end
        end
    end

endmodule

[hdl/utf8_stream_validator_core.sv]
// ============================================================================
// utf8_stream_validator_core
// Byte-serial UTF-8 validator with safe-truncation tracking.
// ============================================================================
// Takes one request per cycle while full is low and returns one result per
// request, in order, so a full-rate stream of bytes gives a full-rate stream
// of results. A request is classified in the front stage, waits in a short
// command queue, and the back end steps the 9-state table automaton and the
// prefix tracker together; results wait in a small output queue. Unstalled,
// a request passes the front register and both queues to the output ports.
// The automaton/tracker update is the rate-setting loop. The user must write
// capacity via the config port while idle; the block does not enforce this.
module utf8_stream_validator_core #(
    parameter int LENGTH_BITS = 16,
    parameter int CMD_DEPTH   = 2,
    parameter int RES_DEPTH   = 2
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        push,
    input  ustv_pkg::t_in_item          i_item,
    output logic                        full,
    output logic                        empty,
    input  logic                        pop,
    output ustv_pkg::t_out_item         o_result,
    input  logic                        i_cfg_wr_en,
    input  logic [ustv_pkg::CFG_W-1:0]  i_cfg_wr_data
);

    logic                 w_front_valid;
    ustv_pkg::t_cmd       w_front_cmd;
    logic                 w_cmdq_full;
    logic                 w_cmdq_empty;
    ustv_pkg::t_cmd       w_cmdq_head;
    logic                 w_cmd_take;
    logic                 w_res_valid;
    ustv_pkg::t_out_item  w_res;
    logic                 w_resq_full;

    ustv_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_item      (i_item),
        .o_full      (full),
        .o_cmd_valid (w_front_valid),
        .o_cmd       (w_front_cmd),
        .i_cmd_full  (w_cmdq_full)
    );

    ustv_queue #(
        .T     (ustv_pkg::t_cmd),
        .DEPTH (CMD_DEPTH)
    ) u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_front_valid),
        .i_data  (w_front_cmd),
        .o_full  (w_cmdq_full),
        .i_pop   (w_cmd_take),
        .o_data  (w_cmdq_head),
        .o_empty (w_cmdq_empty)
    );

    ustv_back #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_cmd_valid   (!w_cmdq_empty),
        .i_cmd         (w_cmdq_head),
        .o_cmd_take    (w_cmd_take),
        .o_res_valid   (w_res_valid),
        .o_res         (w_res),
        .i_res_full    (w_resq_full)
    );

    ustv_queue #(
        .T     (ustv_pkg::t_out_item),
        .DEPTH (RES_DEPTH)
    ) u_resq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_valid),
        .i_data  (w_res),
        .o_full  (w_resq_full),
        .i_pop   (pop),
        .o_data  (o_result),
        .o_empty (empty)
    );

`ifndef NO_ASSERTIONS
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> empty && !full)
        else $error("queues not cleared by reset");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_result.status == ustv_pkg::STATUS_VALID ||
                    o_result.status == ustv_pkg::STATUS_INVALID ||
                    o_result.status == ustv_pkg::STATUS_INCOMPLETE))
        else $error("undefined status code");

    a_invalid_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && o_result.status == ustv_pkg::STATUS_INVALID |-> o_result.copy_stopped)
        else $error("invalid result without halted tracking");
`endif

endmodule

[tb/sv/ustv_tb_pkg.sv]
// ============================================================================
// ustv_tb_pkg
// Result tracking for the UTF-8 stream validator testbench: an own model of
// the byte automaton and the safe-prefix tracker, and an in-order check of
// every result against the value predicted when its request was taken.
// ============================================================================
package ustv_tb_pkg;

    import ustv_pkg::*;

    localparam logic [7:0]       NUL_BYTE  = 8'h00;
    localparam logic [CFG_W-1:0] CAP_LIMIT = 17'd65536;

    // next state per automaton state, one nibble per byte class, class 0 leftmost
    localparam logic [0:8][0:11][3:0] DFA_NEXT = {
        48'h0123_5871_1146,
        48'h1111_1111_1111,
        48'h1011_1110_1011,
        48'h1211_1112_1211,
        48'h1111_1112_1111,
        48'h1211_1111_1211,
        48'h1111_1113_1311,
        48'h1311_1113_1311,
        48'h1311_1111_1111
    };

    class utf8_prefix_scoreboard;

        t_out_item          expected_q[$];
        int unsigned        fail_count;
        logic [STATE_W-1:0] dfa_st;
        logic [CFG_W-1:0]   taken;
        logic [SAFE_W-1:0]  boundary;
        logic               halted;
        logic [CFG_W-1:0]   capacity;

        function new();
            fail_count = 0;
            capacity   = CAPACITY_RESET;
            restart_tracking();
        endfunction

        function void restart_tracking();
            dfa_st   = ST_ACCEPT;
            taken    = '0;
            boundary = '0;
            halted   = 1'b0;
        endfunction

        function void set_capacity(logic [CFG_W-1:0] value);
            capacity = value;
        endfunction

        function int unsigned pending();
            return expected_q.size();
        endfunction

        function logic [3:0] class_of(logic [7:0] b);
            if (b < 8'h80) return 4'd0;
            if (b < 8'h90) return 4'd1;
            if (b < 8'hA0) return 4'd9;
            if (b < 8'hC0) return 4'd7;
            if (b < 8'hC2) return 4'd8;
            if (b < 8'hE0) return 4'd2;
            if (b == 8'hE0) return 4'd10;
            if (b == 8'hED) return 4'd4;
            if (b < 8'hF0) return 4'd3;
            if (b == 8'hF0) return 4'd11;
            if (b < 8'hF4) return 4'd6;
            if (b == 8'hF4) return 4'd5;
            return 4'd8;
        endfunction

        function void note_request(t_in_item req);
            t_out_item        res;
            logic [CFG_W-1:0] lim;
            logic [3:0]       cur;
            if (req.action == ACTION_RESTART) begin
                restart_tracking();
            end else if (req.data_byte == NUL_BYTE) begin
                halted = 1'b1;
            end else begin
                cur    = (dfa_st > ST_LAST) ? ST_REJECT : dfa_st;
                dfa_st = DFA_NEXT[cur][class_of(req.data_byte)];
                if (!halted) begin
                    lim = (capacity > CAP_LIMIT) ? CAP_LIMIT : capacity;
                    if (taken >= lim || dfa_st == ST_REJECT) begin
                        halted = 1'b1;
                    end else begin
                        taken = taken + 1'b1;
                        if (taken >= lim) begin
                            halted = 1'b1;
                        end else if (dfa_st == ST_ACCEPT) begin
                            boundary = taken[SAFE_W-1:0];
                        end
                    end
                end
            end
            if (dfa_st == ST_ACCEPT) begin
                res.status = STATUS_VALID;
            end else if (dfa_st == ST_REJECT || dfa_st > ST_LAST) begin
                res.status = STATUS_INVALID;
            end else begin
                res.status = STATUS_INCOMPLETE;
            end
            res.safe_length  = boundary;
            res.copy_stopped = halted;
            expected_q.push_back(res);
        endfunction

        function void check_result(t_out_item got);
            t_out_item want;
            if (expected_q.size() == 0) begin
                $error("unexpected result: status %0d safe_length %0d copy_stopped %0d",
                       got.status, got.safe_length, got.copy_stopped);
                fail_count++;
                return;
            end
            want = expected_q.pop_front();
            if (got.status !== want.status) begin
                $error("status: expected %0d, actual %0d", want.status, got.status);
                fail_count++;
            end
            if (got.safe_length !== want.safe_length) begin
                $error("safe_length: expected %0d, actual %0d",
                       want.safe_length, got.safe_length);
                fail_count++;
            end
            if (got.copy_stopped !== want.copy_stopped) begin
                $error("copy_stopped: expected %0d, actual %0d",
                       want.copy_stopped, got.copy_stopped);
                fail_count++;
            end
        endfunction

    endclass

endpackage

[tb/sv/utf8_stream_validator_core_test.sv]
// ============================================================================
// utf8_stream_validator_core_test
// Drives byte requests and restarts into the validator under several buffer
// capacities and handshake stall patterns, and checks every result in order.
// ============================================================================
module utf8_stream_validator_core_test;

    timeunit 1ns;
    timeprecision 1ps;

    import ustv_pkg::*;
    import ustv_tb_pkg::*;

    localparam int PHASE_ITEMS = 125;
    localparam int NUM_PHASES  = 8;
    localparam int SETTLE      = 8;

    logic             i_clk         = 1'b0;
    logic             i_rst_n       = 1'b0;
    logic             push          = 1'b0;
    t_in_item         i_item        = '0;
    logic             full;
    logic             empty;
    logic             pop           = 1'b0;
    t_out_item        o_result;
    logic             i_cfg_wr_en   = 1'b0;
    logic [CFG_W-1:0] i_cfg_wr_data = '0;

    utf8_prefix_scoreboard prefix_sb;
    int unsigned           sender_idle_pct   = 0;
    int unsigned           receiver_stall_pct = 0;
    int unsigned           phase_sent;
    logic [7:0]            char_bytes[$];

    utf8_stream_validator_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .i_item        (i_item),
        .full          (full),
        .empty         (empty),
        .pop           (pop),
        .o_result      (o_result),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data)
    );

    always #5 i_clk = ~i_clk;

    initial begin
        #5ms;
        $display("Test completed with failures");
        $finish;
    end

    // take results, stall at random
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                prefix_sb.check_result(o_result);
            end
            pop <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    task automatic send_request(input logic act, input logic [7:0] data);
        int unsigned gap;
        t_in_item    req;
        gap = 0;
        while (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
            gap++;
        end
        req.action    = act;
        req.data_byte = data;
        if (gap != 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push   <= 1'b1;
        i_item <= req;
        do @(posedge i_clk); while (full);
        prefix_sb.note_request(req);
        phase_sent++;
    endtask

    task automatic feed(input logic [7:0] data);
        send_request(ACTION_FEED, data);
    endtask

    task automatic drain();
        push <= 1'b0;
        while (prefix_sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_capacity(input logic [CFG_W-1:0] value);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        prefix_sb.set_capacity(value);
    endtask

    function automatic logic [7:0] cont_byte(input int unsigned lo, input int unsigned hi);
        return 8'($urandom_range(hi, lo));
    endfunction

    // build one well-formed character of 1 to 4 bytes
    function automatic void build_char();
        logic [7:0] lead;
        char_bytes.delete();
        case ($urandom_range(4, 1))
            1: begin
                char_bytes.push_back(8'($urandom_range(127, 1)));
            end
            2: begin
                char_bytes.push_back(8'($urandom_range(8'hDF, 8'hC2)));
                char_bytes.push_back(cont_byte(8'h80, 8'hBF));
            end
            3: begin
                lead = 8'($urandom_range(8'hEF, 8'hE0));
                char_bytes.push_back(lead);
                if (lead == 8'hE0) begin
                    char_bytes.push_back(cont_byte(8'hA0, 8'hBF));
                end else if (lead == 8'hED) begin
                    char_bytes.push_back(cont_byte(8'h80, 8'h9F));
                end else begin
                    char_bytes.push_back(cont_byte(8'h80, 8'hBF));
                end
                char_bytes.push_back(cont_byte(8'h80, 8'hBF));
            end
            default: begin
                lead = 8'($urandom_range(8'hF4, 8'hF0));
                char_bytes.push_back(lead);
                if (lead == 8'hF0) begin
                    char_bytes.push_back(cont_byte(8'h90, 8'hBF));
                end else if (lead == 8'hF4) begin
                    char_bytes.push_back(cont_byte(8'h80, 8'h8F));
                end else begin
                    char_bytes.push_back(cont_byte(8'h80, 8'hBF));
                end
                char_bytes.push_back(cont_byte(8'h80, 8'hBF));
                char_bytes.push_back(cont_byte(8'h80, 8'hBF));
            end
        endcase
    endfunction

    task automatic send_random_unit();
        int unsigned pick;
        int unsigned cut;
        pick = $urandom_range(99);
        if (pick < 74) begin
            build_char();
            cut = char_bytes.size();
            // truncate some multibyte characters
            if (pick >= 62 && cut > 1) begin
                cut = $urandom_range(cut - 1, 1);
            end
            for (int k = 0; k < cut; k++) begin
                feed(char_bytes[k]);
            end
        end else if (pick < 86) begin
            feed(8'($urandom_range(255)));
        end else if (pick < 91) begin
            feed(NUL_BYTE);
        end else begin
            send_request(ACTION_RESTART, 8'($urandom_range(255)));
        end
    endtask

    initial begin
        logic [CFG_W-1:0] cap_plan [0:NUM_PHASES-1];
        logic [7:0]       directed [$];
        prefix_sb = new();
        cap_plan  = '{17'd1, 17'd0, 17'h1FFFF, 17'd3, 17'd65536, 17'd12, 17'd2, 17'd40};
        cap_plan[NUM_PHASES-1] = 17'($urandom_range(64, 1));
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        directed = '{8'h41, 8'hC2, 8'h80, 8'hE0, 8'hA0, 8'h80, 8'hED, 8'h9F, 8'hBF,
                     8'hF0, 8'h90, 8'h80, 8'h80, 8'hF4, 8'h8F, 8'hBF, 8'hBF,
                     8'hC0, 8'h41};
        foreach (directed[k]) begin
            feed(directed[k]);
        end
        send_request(ACTION_RESTART, 8'hFF);
        feed(8'hE1);
        feed(NUL_BYTE);
        feed(8'h80);
        send_request(ACTION_RESTART, NUL_BYTE);
        feed(8'hFF);
        drain();

        for (int p = 0; p < NUM_PHASES; p++) begin
            write_capacity(cap_plan[p]);
            case (p % 4)
                0: begin
                    sender_idle_pct    = 0;
                    receiver_stall_pct = 0;
                end
                1: begin
                    sender_idle_pct    = 87;
                    receiver_stall_pct = 0;
                end
                2: begin
                    sender_idle_pct    = 0;
                    receiver_stall_pct = 87;
                end
                default: begin
                    sender_idle_pct    = 26;
                    receiver_stall_pct = 26;
                end
            endcase
            phase_sent = 0;
            while (phase_sent < PHASE_ITEMS) begin
                send_random_unit();
            end
            drain();
        end

        if (prefix_sb.fail_count == 0 && prefix_sb.pending() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
